FILE: src/gtg_pkg.sv
// Shared types and constants of the go-to-goal controller.
// No dependencies.
package gtg_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int HEAD_WIDTH = 16;
    localparam int GUARD = 10;
    localparam int TABLE_LEN = 24;
    localparam int ANG_WIDTH = 33;
    localparam logic signed [ANG_WIDTH-1:0] ANG_PI = 33'sd1686629713;
    localparam logic signed [ANG_WIDTH-1:0] ANG_HALF_PI = 33'sd843314857;

    localparam logic [2:0] REG_GOAL_X = 3'd0;
    localparam logic [2:0] REG_GOAL_Y = 3'd1;
    localparam logic [2:0] REG_LIN_GAIN = 3'd2;
    localparam logic [2:0] REG_ANG_GAIN = 3'd3;
    localparam logic [2:0] REG_DIST_LIM = 3'd4;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pose_x;
        logic signed [DATA_WIDTH-1:0] pose_y;
        logic signed [HEAD_WIDTH-1:0] heading;
    } pose_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] linear_speed;
        logic signed [DATA_WIDTH-1:0] turn_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] goal_x;
        logic signed [DATA_WIDTH-1:0] goal_y;
        logic [DATA_WIDTH-1:0] linear_gain;
        logic [DATA_WIDTH-1:0] angular_gain;
        logic [DATA_WIDTH-2:0] distance_limit;
    } cfg_t;

    function automatic logic signed [ANG_WIDTH-1:0] atan_entry(input int i);
        logic signed [ANG_WIDTH-1:0] r;
        case (i)
            0: r = 33'sd421657428;
            1: r = 33'sd248918915;
            2: r = 33'sd131521918;
            3: r = 33'sd66762579;
            4: r = 33'sd33510843;
            5: r = 33'sd16771758;
            6: r = 33'sd8387925;
            7: r = 33'sd4194219;
            8: r = 33'sd2097141;
            9: r = 33'sd1048575;
            default: r = ANG_WIDTH'(64'sd1 <<< (29 - i));
        endcase
        return r;
    endfunction

    function automatic logic [31:0] gain_comp(input int n);
        logic [31:0] c;
        case (n)
            0: c = 32'd1073741824;
            1: c = 32'd536870912;
            2: c = 32'd429496730;
            3: c = 32'd404232217;
            4: c = 32'd398013260;
            5: c = 32'd396464571;
            6: c = 32'd396077777;
            7: c = 32'd395981102;
            8: c = 32'd395956935;
            9: c = 32'd395950894;
            10: c = 32'd395949384;
            11: c = 32'd395949007;
            12: c = 32'd395948913;
            13: c = 32'd395948890;
            14: c = 32'd395948885;
            default: c = 32'd395948884;
        endcase
        return c;
    endfunction

endpackage

FILE: src/gtg_regs.sv
// APB register file of the go-to-goal controller.
// Depends on gtg_pkg.
module gtg_regs #(
    parameter int DATA_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic signed [DATA_WIDTH-1:0] goal_x,
    output logic signed [DATA_WIDTH-1:0] goal_y,
    output logic [DATA_WIDTH-1:0] linear_gain,
    output logic [DATA_WIDTH-1:0] angular_gain,
    output logic [DATA_WIDTH-2:0] distance_limit
);
    import gtg_pkg::*;

    logic signed [DATA_WIDTH-1:0] goal_x_reg, goal_y_reg;
    logic [DATA_WIDTH-1:0] lin_gain_reg, ang_gain_reg;
    logic [DATA_WIDTH-2:0] dist_lim_reg;
    logic [2:0] idx;
    logic wr_en;

    assign idx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            lin_gain_reg <= DATA_WIDTH'(6144);
            ang_gain_reg <= DATA_WIDTH'(16384);
            dist_lim_reg <= (DATA_WIDTH-1)'(4096);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GOAL_X:   goal_x_reg   <= pwdata[DATA_WIDTH-1:0];
                REG_GOAL_Y:   goal_y_reg   <= pwdata[DATA_WIDTH-1:0];
                REG_LIN_GAIN: lin_gain_reg <= pwdata[DATA_WIDTH-1:0];
                REG_ANG_GAIN: ang_gain_reg <= pwdata[DATA_WIDTH-1:0];
                REG_DIST_LIM: dist_lim_reg <= pwdata[DATA_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_GOAL_X:   prdata = 32'(unsigned'(goal_x_reg));
            REG_GOAL_Y:   prdata = 32'(unsigned'(goal_y_reg));
            REG_LIN_GAIN: prdata = 32'(lin_gain_reg);
            REG_ANG_GAIN: prdata = 32'(ang_gain_reg);
            REG_DIST_LIM: prdata = 32'(dist_lim_reg);
            default:      prdata = '0;
        endcase
    end

    assign goal_x = goal_x_reg;
    assign goal_y = goal_y_reg;
    assign linear_gain = lin_gain_reg;
    assign angular_gain = ang_gain_reg;
    assign distance_limit = dist_lim_reg;
endmodule

FILE: src/gtg_cordic.sv
// Pipelined CORDIC: rotation into the body frame, then vectoring.
// Depends on gtg_pkg.
module gtg_cordic #(
    parameter int DATA_WIDTH = 16,
    parameter int CORDIC_STAGES = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [DATA_WIDTH+1:0] err_x,
    input  logic signed [DATA_WIDTH+1:0] err_y,
    input  logic signed [gtg_pkg::ANG_WIDTH-1:0] angle,
    output logic out_valid,
    output logic signed [DATA_WIDTH+gtg_pkg::GUARD+3:0] mag,
    output logic signed [gtg_pkg::ANG_WIDTH-1:0] bearing
);
    import gtg_pkg::*;

    localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int XW = DATA_WIDTH + GUARD + 4;

    logic                        rv_reg [0:NS];
    logic signed [XW-1:0]        rx_reg [0:NS];
    logic signed [XW-1:0]        ry_reg [0:NS];
    logic signed [ANG_WIDTH-1:0] rz_reg [0:NS];

    logic                        vv_reg [0:NS];
    logic signed [XW-1:0]        vx_reg [0:NS];
    logic signed [XW-1:0]        vy_reg [0:NS];
    logic signed [ANG_WIDTH-1:0] va_reg [0:NS];
    logic                        vz_reg [0:NS];

    logic signed [XW-1:0] ex, ey, px_next, py_next;
    logic signed [ANG_WIDTH-1:0] a_next, pa_next;
    logic pz_next;

    always_comb
    begin
        ex = XW'(err_x) <<< GUARD;
        ey = XW'(err_y) <<< GUARD;
        a_next = angle;
        if (angle > ANG_HALF_PI)
        begin
            a_next = angle - ANG_PI;
            ex = -ex;
            ey = -ey;
        end
        else if (angle < -ANG_HALF_PI)
        begin
            a_next = angle + ANG_PI;
            ex = -ex;
            ey = -ey;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else
            rv_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0] <= ex;
        ry_reg[0] <= ey;
        rz_reg[0] <= -a_next;
    end

    for (genvar i = 0; i < NS; i++) begin : g_rot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[i+1] <= 1'b0;
            else
                rv_reg[i+1] <= rv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (!rz_reg[i][ANG_WIDTH-1])
            begin
                rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                rz_reg[i+1] <= rz_reg[i] - atan_entry(i);
            end
            else
            begin
                rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                rz_reg[i+1] <= rz_reg[i] + atan_entry(i);
            end
        end
    end

    always_comb
    begin
        px_next = rx_reg[NS];
        py_next = ry_reg[NS];
        pa_next = '0;
        pz_next = (rx_reg[NS] == '0) && (ry_reg[NS] == '0);
        if (rx_reg[NS] < 0)
        begin
            if (ry_reg[NS] >= 0)
            begin
                px_next = ry_reg[NS];
                py_next = -rx_reg[NS];
                pa_next = ANG_HALF_PI;
            end
            else
            begin
                px_next = -ry_reg[NS];
                py_next = rx_reg[NS];
                pa_next = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vv_reg[0] <= 1'b0;
        else
            vv_reg[0] <= rv_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        vx_reg[0] <= px_next;
        vy_reg[0] <= py_next;
        va_reg[0] <= pa_next;
        vz_reg[0] <= pz_next;
    end

    for (genvar i = 0; i < NS; i++) begin : g_vec
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vv_reg[i+1] <= 1'b0;
            else
                vv_reg[i+1] <= vv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            vz_reg[i+1] <= vz_reg[i];
            if (!vy_reg[i][XW-1])
            begin
                vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                va_reg[i+1] <= va_reg[i] + atan_entry(i);
            end
            else
            begin
                vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                va_reg[i+1] <= va_reg[i] - atan_entry(i);
            end
        end
    end

    assign out_valid = vv_reg[NS];
    assign mag = vz_reg[NS] ? '0 : vx_reg[NS];
    assign bearing = vz_reg[NS] ? '0 : va_reg[NS];
endmodule

FILE: src/gtg_scale.sv
// Gain compensation, distance clamp and gain scaling with saturation.
// Depends on gtg_pkg.
module gtg_scale #(
    parameter int DATA_WIDTH = 16,
    parameter int CORDIC_STAGES = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic signed [DATA_WIDTH+13:0] mag,
    input  logic signed [gtg_pkg::ANG_WIDTH-1:0] bearing,
    input  logic [DATA_WIDTH-1:0] linear_gain,
    input  logic [DATA_WIDTH-1:0] angular_gain,
    input  logic [DATA_WIDTH-2:0] distance_limit,
    output logic out_valid,
    output gtg_pkg::cmd_t result
);
    import gtg_pkg::*;

    localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int XW = DATA_WIDTH + GUARD + 4;
    localparam logic [31:0] COMP = gain_comp(NS);
    localparam int MAGW = ANG_WIDTH - 1;
    localparam int PW = XW + 31;
    localparam int DW = PW - 30;
    localparam int LPW = DW + DATA_WIDTH;
    localparam int APW = MAGW + DATA_WIDTH;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [PW-1:0] prod_reg;
    logic [MAGW-1:0] amag1_reg, amag2_reg;
    logic neg1_reg, neg2_reg, neg3_reg;
    logic [DATA_WIDTH-2:0] dist_reg;
    logic [LPW-1:0] lprod_reg;
    logic [APW-1:0] aprod_reg;
    cmd_t res_reg;

    logic [XW-2:0] xv;
    logic [DW-1:0] d_full, d_rnd;
    logic [DATA_WIDTH-2:0] d_next;
    logic [LPW-1:0] l_sh;
    logic [APW-1:0] a_sh;
    logic [DATA_WIDTH-1:0] lin_next, tr_next;
    logic [DATA_WIDTH-1:0] smax;

    assign smax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    assign xv = mag[XW-1] ? '0 : mag[XW-2:0];

    always_comb
    begin
        d_full = DW'(prod_reg >> 30);
        d_rnd = (d_full + DW'(1 << (GUARD - 1))) >> GUARD;
        if (d_rnd > DW'(distance_limit))
            d_next = distance_limit;
        else
            d_next = d_rnd[DATA_WIDTH-2:0];
    end

    always_comb
    begin
        l_sh = (lprod_reg + LPW'(2048)) >> 12;
        a_sh = (aprod_reg + (APW'(1) << 29)) >> 30;
        lin_next = (l_sh > LPW'(smax)) ? smax : l_sh[DATA_WIDTH-1:0];
        if (neg3_reg)
        begin
            if (a_sh > APW'(smax) + APW'(1))
                tr_next = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            else
                tr_next = -a_sh[DATA_WIDTH-1:0];
        end
        else
            tr_next = (a_sh > APW'(smax)) ? smax : a_sh[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PW'(xv) * PW'(COMP);
        neg1_reg  <= bearing[ANG_WIDTH-1];
        amag1_reg <= bearing[ANG_WIDTH-1] ? MAGW'(-bearing) : bearing[MAGW-1:0];
        dist_reg  <= d_next;
        neg2_reg  <= neg1_reg;
        amag2_reg <= amag1_reg;
        lprod_reg <= LPW'(dist_reg) * LPW'(linear_gain);
        aprod_reg <= APW'(amag2_reg) * APW'(angular_gain);
        neg3_reg  <= neg2_reg;
        res_reg.linear_speed <= lin_next;
        res_reg.turn_rate <= tr_next;
    end

    assign out_valid = v4_reg;
    assign result = res_reg;
endmodule

FILE: src/go_to_goal_p_controller_core.sv
// Go-to-goal proportional controller, top level.
// Throughput: one pose per cycle; busy is held low, the CORDIC pipeline sets the rate.
// Reset: rst_n asynchronous active low clears valid bits and loads register defaults.
// The receiver cannot stall; each result shows on done for one cycle.
// Depends on gtg_pkg, gtg_regs, gtg_cordic, gtg_scale.
module go_to_goal_p_controller_core #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  gtg_pkg::pose_t pose,
    output logic done,
    output gtg_pkg::cmd_t cmd,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gtg_pkg::*;

    logic signed [DATA_WIDTH-1:0] goal_x, goal_y;
    logic [DATA_WIDTH-1:0] linear_gain, angular_gain;
    logic [DATA_WIDTH-2:0] distance_limit;
    logic v_reg;
    logic signed [DATA_WIDTH+1:0] ex_reg, ey_reg;
    logic signed [ANG_WIDTH-1:0] ang_reg;
    logic cv;
    logic signed [DATA_WIDTH+13:0] mag;
    logic signed [ANG_WIDTH-1:0] bearing;

    assign busy = 1'b0;

    gtg_regs #(.DATA_WIDTH(DATA_WIDTH)) u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .goal_x(goal_x), .goal_y(goal_y), .linear_gain(linear_gain),
        .angular_gain(angular_gain), .distance_limit(distance_limit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        ex_reg  <= (DATA_WIDTH+2)'(goal_x) - (DATA_WIDTH+2)'(pose.pose_x);
        ey_reg  <= (DATA_WIDTH+2)'(goal_y) - (DATA_WIDTH+2)'(pose.pose_y);
        ang_reg <= ANG_WIDTH'(pose.heading) <<< 16;
    end

    gtg_cordic #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .clk(clk), .rst_n(rst_n), .in_valid(v_reg), .err_x(ex_reg), .err_y(ey_reg),
        .angle(ang_reg), .out_valid(cv), .mag(mag), .bearing(bearing)
    );

    gtg_scale #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_scale (
        .clk(clk), .rst_n(rst_n), .in_valid(cv), .mag(mag), .bearing(bearing),
        .linear_gain(linear_gain), .angular_gain(angular_gain),
        .distance_limit(distance_limit), .out_valid(done), .result(cmd)
    );
endmodule

FILE: test/tb.sv
// Testbench for go_to_goal_p_controller_core: drives poses and APB register writes,
// predicts each speed command with a bit-exact fixed-point model and checks in order.
// Depends on gtg_pkg and the controller RTL.
`timescale 1ns / 100ps

module tb;
    import gtg_pkg::*;

    localparam int STAGES = 14;
    localparam int LATENCY = 2 * STAGES + 7;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pose_t pose = '0;
    logic done;
    cmd_t cmd;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    go_to_goal_p_controller_core #(.CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pose(pose),
        .done(done), .cmd(cmd), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cfg_t cfg_shadow;
    pose_t pose_queue[$];
    cmd_t cmd_expected[$];
    int errors = 0;
    longint cycles = 0;
    int gap_left = 0;
    bit idle_enable = 1'b1;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_q29(int i);
        case (i)
            0: return 421657428;
            1: return 248918915;
            2: return 131521918;
            3: return 66762579;
            4: return 33510843;
            5: return 16771758;
            6: return 8387925;
            7: return 4194219;
            8: return 2097141;
            9: return 1048575;
            default: return longint'(1) << (29 - i);
        endcase
    endfunction

    function automatic cmd_t predict_command(pose_t p, cfg_t c);
        longint a, x, y, z, ang, t, dx, dy, smax;
        longint unsigned distance, comp, xv, hi, lo, lin, mag, tr, lim;
        cmd_t r;
        a = longint'(p.heading) * 65536;
        x = (longint'(c.goal_x) - longint'(p.pose_x)) * 1024;
        y = (longint'(c.goal_y) - longint'(p.pose_y)) * 1024;
        ang = 0;
        distance = 0;
        comp = 64'd1 << 30;
        smax = 32767;
        lim = c.distance_limit;
        if (a > 843314857) begin a -= 1686629713; x = -x; y = -y; end
        else if (a < -843314857) begin a += 1686629713; x = -x; y = -y; end
        z = -a;
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin x -= dx; y += dy; z -= atan_q29(i); end
            else begin x += dx; y -= dy; z += atan_q29(i); end
        end
        if (x != 0 || y != 0) begin
            if (x < 0) begin
                if (y >= 0) begin t = x; x = y; y = -t; ang = 843314857; end
                else begin t = x; x = -y; y = t; ang = -843314857; end
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (y >= 0) begin x += dx; y -= dy; ang += atan_q29(i); end
                else begin x -= dx; y += dy; ang -= atan_q29(i); end
            end
            for (int i = 0; i < STAGES; i++)
                comp = comp - comp / ((64'd1 << (2 * i)) + 64'd1);
            xv = (x < 0) ? 0 : longint'(x);
            hi = xv >> 15;
            lo = xv & 64'h7FFF;
            distance = (hi * comp + ((lo * comp) >> 15)) >> 15;
            distance = (distance + 512) >> 10;
        end
        if (distance > lim)
            distance = lim;
        lin = (distance * c.linear_gain + 2048) >> 12;
        if (lin > smax)
            lin = smax;
        mag = (ang < 0) ? -ang : ang;
        tr = (mag * c.angular_gain + (64'd1 << 29)) >> 30;
        if (ang < 0) begin
            if (tr > smax + 1)
                tr = smax + 1;
            r.turn_rate = 16'(-longint'(tr));
        end else begin
            if (tr > smax)
                tr = smax;
            r.turn_rate = 16'(tr);
        end
        r.linear_speed = 16'(lin);
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                cmd_expected.push_back(predict_command(pose, cfg_shadow));
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pose_queue.size() > 0)
            begin
                if (idle_enable && $urandom_range(0, 9) == 0)
                begin
                    start <= 1'b0;
                    gap_left <= $urandom_range(0, 6);
                end
                else
                begin
                    start <= 1'b1;
                    pose <= pose_queue.pop_front();
                end
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cmd_t want;
        if (rst_n && done)
        begin
            if (cmd_expected.size() == 0)
            begin
                $display("%0t: unexpected command %h", $time, cmd);
                errors++;
            end
            else
            begin
                want = cmd_expected.pop_front();
                if (cmd.linear_speed !== want.linear_speed)
                begin
                    $display("%0t: linear_speed expected %0d actual %0d", $time,
                             want.linear_speed, cmd.linear_speed);
                    errors++;
                end
                if (cmd.turn_rate !== want.turn_rate)
                begin
                    $display("%0t: turn_rate expected %0d actual %0d", $time,
                             want.turn_rate, cmd.turn_rate);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_GOAL_X: cfg_shadow.goal_x = value[15:0];
            REG_GOAL_Y: cfg_shadow.goal_y = value[15:0];
            REG_LIN_GAIN: cfg_shadow.linear_gain = value[15:0];
            REG_ANG_GAIN: cfg_shadow.angular_gain = value[15:0];
            REG_DIST_LIM: cfg_shadow.distance_limit = value[14:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pose_queue.size() > 0 || start) @(posedge clk);
        while (cmd_expected.size() > 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic add_pose(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] hd);
        pose_t p;
        p.pose_x = px;
        p.pose_y = py;
        p.heading = hd;
        pose_queue.push_back(p);
    endtask

    function automatic logic [15:0] pick_heading();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 2 * 25736) - 25736);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [15:0] px, py;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    px = 16'(cfg_shadow.goal_x + $signed(16'($urandom_range(0, 64))) - 32);
                    py = 16'(cfg_shadow.goal_y + $signed(16'($urandom_range(0, 64))) - 32);
                end
                1:
                begin
                    px = cfg_shadow.goal_x;
                    py = 16'($urandom);
                end
                default:
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
            endcase
            add_pose(px, py, pick_heading());
        end
    endtask

    initial
    begin
        cfg_shadow.goal_x = 16'sd0;
        cfg_shadow.goal_y = 16'sd0;
        cfg_shadow.linear_gain = 16'd6144;
        cfg_shadow.angular_gain = 16'd16384;
        cfg_shadow.distance_limit = 15'd4096;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_pose(16'h0000, 16'h0000, 16'h0000);
        add_pose(16'h0000, 16'h0000, 16'h7FFF);
        add_pose(16'h0800, 16'h0000, 16'h0000);
        add_pose(16'hF800, 16'h0000, 16'h0000);
        add_pose(16'h7FFF, 16'h7FFF, 16'h8000);
        add_pose(16'h8000, 16'h8000, 16'h7FFF);
        add_pose(16'h8000, 16'h7FFF, 16'h3244);
        add_pose(16'h7FFF, 16'h8000, 16'hCDBC);
        add_pose(16'h0000, 16'h0400, 16'h3243);
        add_pose(16'h0000, 16'hFC00, 16'hCDBD);
        add_pose(16'h1234, 16'hEDCB, 16'h0001);
        add_pose(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        write_reg(REG_LIN_GAIN, 32'h0000FFFF);
        write_reg(REG_ANG_GAIN, 32'h0000FFFF);
        write_reg(REG_DIST_LIM, 32'h00007FFF);
        write_reg(REG_GOAL_X, 32'h00007FFF);
        write_reg(REG_GOAL_Y, 32'h00008000);
        add_pose(16'h8000, 16'h7FFF, 16'h0000);
        add_pose(16'h7FFF, 16'h8000, 16'h6000);
        add_pose(16'h7FFF, 16'h8000, 16'h0000);
        add_pose(16'h0000, 16'h0000, 16'h8000);
        random_phase(120);
        drain();

        write_reg(REG_LIN_GAIN, 32'h00000000);
        write_reg(REG_ANG_GAIN, 32'h00000000);
        write_reg(REG_DIST_LIM, 32'h00000000);
        write_reg(REG_GOAL_X, 32'h00008000);
        write_reg(REG_GOAL_Y, 32'h00007FFF);
        random_phase(60);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_GOAL_X, $urandom);
            write_reg(REG_GOAL_Y, $urandom);
            write_reg(REG_LIN_GAIN, $urandom);
            write_reg(REG_ANG_GAIN, $urandom);
            write_reg(REG_DIST_LIM, $urandom);
            random_phase(90);
            drain();
        end

        write_reg(REG_GOAL_X, 32'h0);
        write_reg(REG_GOAL_Y, 32'h0);
        write_reg(REG_LIN_GAIN, 32'd6144);
        write_reg(REG_ANG_GAIN, 32'd16384);
        write_reg(REG_DIST_LIM, 32'd4096);
        idle_enable = 1'b0;
        random_phase(60);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
